// File: rtl/core/pdsd_pkg.sv
package pdsd_pkg;

    // field widths
    localparam int MEAS_W  = 24;
    localparam int ERR_W   = MEAS_W + 1;       // goal - measured
    localparam int NUM_W   = ERR_W + 3;        // e0 + 2e1 - 2e3 - e4
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = GAIN_W + ERR_W;   // gain * error, also the sum
    localparam int DIV_W   = PROD_W - 1;       // magnitude of the sum
    localparam int PER_W   = 16;
    localparam int DSR_W   = PER_W + 3;        // period * 8
    localparam int DRV_W   = 16;
    localparam int DB_W    = 15;
    localparam int FIN_W   = ERR_W + 1;        // quotient with deadband added
    localparam int HIST_D  = 5;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // two quotient bits per divider step
    localparam int DERIV_STEPS = NUM_W / 2;
    localparam int SCALE_STEPS = DIV_W / 2;
    localparam int STEP_W      = $clog2(SCALE_STEPS + 1);

    localparam logic [DSR_W-1:0] SCALE = DSR_W'(100000);

    typedef enum logic [IDX_W-1:0] {
        REG_GOAL     = 3'd0,
        REG_P_GAIN   = 3'd1,
        REG_D_GAIN   = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_OUT_MIN  = 3'd4,
        REG_OUT_MAX  = 3'd5,
        REG_DEADBAND = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [MEAS_W-1:0] goal;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic        [PER_W-1:0]  sample_period;
        logic signed [DRV_W-1:0]  out_min;
        logic signed [DRV_W-1:0]  out_max;
        logic        [DB_W-1:0]   deadband_comp;
    } t_cfg;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,   // error into history
        OP_NUM,      // derivative numerator
        OP_LOAD_D,   // start numerator / (period*8)
        OP_FIX_D,    // sign the derivative
        OP_MUL_P,
        OP_MUL_D,
        OP_ADD,
        OP_LOAD_S,   // start sum / scale
        OP_FIX_S,
        OP_FINISH    // deadband, clamp, output register
    } t_op;

endpackage

// File: rtl/core/pd_controller_smoothed_derivative.sv
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+----------------------------
// input     | in        | i_in_valid / o_in_stall      | i_measured  (s24)
// result    | out       | o_out_valid / i_out_stall    | o_drive     (s16)
// config    | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item at a time: the next input can transfer in the cycle after the result
// register loads, and each item runs twice through the shared radix-4 divider
// (14 steps for the derivative, 20 for the /100000).
// The result register frees the sequencer; a stalled result only holds the
// final step, and the next item is taken as soon as the sequencer is idle.
// Reset (synchronous, active low) clears the error history and loads the
// register defaults; config writes are always ready and registered.
module pd_controller_smoothed_derivative (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // measurement in
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [pdsd_pkg::MEAS_W-1:0] i_measured,
    // drive out
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [pdsd_pkg::DRV_W-1:0]  o_drive,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pdsd_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [pdsd_pkg::CFG_W-1:0]         i_cfg_data
);

    pdsd_pkg::t_cfg cfg;
    pdsd_pkg::t_op  op;
    logic           div_last;

    // writes are registered directly, no back pressure needed
    assign o_cfg_ready = 1'b1;

    pdsd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // sequencer: one command per cycle, waits on the divider and the result register
    pdsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_div_last  (div_last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_op        (op)
    );

    // error history, numerator, multiplier, divider, deadband and clamp
    pdsd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_cfg      (cfg),
        .i_measured (i_measured),
        .o_div_last (div_last),
        .o_drive    (o_drive)
    );

endmodule

// File: rtl/core/pdsd_cfg_regs.sv
module pdsd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [pdsd_pkg::IDX_W-1:0]     i_index,
    input  logic [pdsd_pkg::CFG_W-1:0]     i_data,
    output pdsd_pkg::t_cfg                 o_cfg
);

    pdsd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal          <= '0;
            r_cfg.prop_gain     <= '0;
            r_cfg.deriv_gain    <= '0;
            r_cfg.sample_period <= pdsd_pkg::PER_W'(1);
            r_cfg.out_min       <= {1'b1, {(pdsd_pkg::DRV_W-1){1'b0}}};
            r_cfg.out_max       <= {1'b0, {(pdsd_pkg::DRV_W-1){1'b1}}};
            r_cfg.deadband_comp <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                pdsd_pkg::REG_GOAL:     r_cfg.goal       <= i_data[pdsd_pkg::MEAS_W-1:0];
                pdsd_pkg::REG_P_GAIN:   r_cfg.prop_gain  <= i_data[pdsd_pkg::GAIN_W-1:0];
                pdsd_pkg::REG_D_GAIN:   r_cfg.deriv_gain <= i_data[pdsd_pkg::GAIN_W-1:0];
                pdsd_pkg::REG_PERIOD:   r_cfg.sample_period <= i_data[pdsd_pkg::PER_W-1:0];
                pdsd_pkg::REG_OUT_MIN:  r_cfg.out_min    <= i_data[pdsd_pkg::DRV_W-1:0];
                pdsd_pkg::REG_OUT_MAX:  r_cfg.out_max    <= i_data[pdsd_pkg::DRV_W-1:0];
                pdsd_pkg::REG_DEADBAND: r_cfg.deadband_comp <= i_data[pdsd_pkg::DB_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pdsd_divider.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Dividend is left aligned; after N steps the low 2N bits hold the quotient.
module pdsd_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdsd_pkg::STEP_W-1:0]   i_steps,
    input  logic [pdsd_pkg::DIV_W-1:0]    i_dividend,
    input  logic [pdsd_pkg::DSR_W-1:0]    i_divisor,
    output logic                          o_last,
    output logic [pdsd_pkg::DIV_W-1:0]    o_quotient
);

    localparam int DW = pdsd_pkg::DSR_W;

    logic                          r_busy;
    logic [pdsd_pkg::STEP_W-1:0]   r_cnt;
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_dsr;
    logic [pdsd_pkg::DIV_W-1:0]    r_quo;
    logic [DW:0]                   s1;
    logic [DW:0]                   s2;

    // {quotient bit, new remainder}
    function automatic logic [DW:0] div_bit(input logic [DW-1:0] rem,
                                            input logic bit_in,
                                            input logic [DW-1:0] dsr);
        logic [DW:0] t;
        logic [DW:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, dsr};
        if (t >= {1'b0, dsr}) begin
            return {1'b1, diff[DW-1:0]};
        end
        return {1'b0, t[DW-1:0]};
    endfunction

    always_comb begin
        s1 = div_bit(r_rem, r_quo[pdsd_pkg::DIV_W-1], r_dsr);
        s2 = div_bit(s1[DW-1:0], r_quo[pdsd_pkg::DIV_W-2], r_dsr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pdsd_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= s2[DW-1:0];
            r_quo <= {r_quo[pdsd_pkg::DIV_W-3:0], s1[DW], s2[DW]};
        end
    end

    assign o_last     = r_busy && (r_cnt == pdsd_pkg::STEP_W'(1));
    assign o_quotient = r_quo;

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with zero step count");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last && !i_start) |=> !r_busy)
        else $error("divider still busy after last step");

endmodule

// File: rtl/core/pdsd_datapath.sv
module pdsd_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdsd_pkg::t_op                      i_op,
    input  pdsd_pkg::t_cfg                     i_cfg,
    input  logic signed [pdsd_pkg::MEAS_W-1:0] i_measured,
    output logic                               o_div_last,
    output logic signed [pdsd_pkg::DRV_W-1:0]  o_drive
);

    localparam int EW = pdsd_pkg::ERR_W;
    localparam int NW = pdsd_pkg::NUM_W;
    localparam int PW = pdsd_pkg::PROD_W;
    localparam int DV = pdsd_pkg::DIV_W;
    localparam int FW = pdsd_pkg::FIN_W;

    logic signed [EW-1:0]  r_hist [pdsd_pkg::HIST_D];
    logic signed [NW-1:0]  r_num;
    logic signed [EW-1:0]  r_deriv;
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  r_acc;
    logic signed [EW-1:0]  r_val;
    logic signed [pdsd_pkg::DRV_W-1:0] r_drive;

    logic signed [EW-1:0]  err;
    logic signed [NW-1:0]  num;
    logic        [NW-1:0]  num_mag;
    logic        [DV-1:0]  acc_mag;
    logic        [pdsd_pkg::PER_W-1:0] period;
    logic signed [pdsd_pkg::GAIN_W-1:0] mul_a;
    logic signed [EW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic                  div_start;
    logic [pdsd_pkg::STEP_W-1:0] div_steps;
    logic [DV-1:0]         div_dividend;
    logic [pdsd_pkg::DSR_W-1:0] div_divisor;
    logic [DV-1:0]         quo;
    logic signed [EW-1:0]  quo_s;
    logic signed [FW-1:0]  comp;
    logic signed [FW-1:0]  clamped;
    logic signed [FW-1:0]  lo;
    logic signed [FW-1:0]  hi;

    always_comb begin
        err = EW'(i_cfg.goal) - EW'(i_measured);
        num = NW'(r_hist[0]) + (NW'(r_hist[1]) <<< 1)
            - (NW'(r_hist[3]) <<< 1) - NW'(r_hist[4]);
        num_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
        acc_mag = r_acc[PW-1] ? DV'(-r_acc) : r_acc[DV-1:0];
        period  = (i_cfg.sample_period == '0) ? pdsd_pkg::PER_W'(1) : i_cfg.sample_period;

        mul_a = (i_op == pdsd_pkg::OP_MUL_D) ? i_cfg.deriv_gain : i_cfg.prop_gain;
        mul_b = (i_op == pdsd_pkg::OP_MUL_D) ? r_deriv : r_hist[0];
        prod  = PW'(mul_a) * PW'(mul_b);

        div_start    = (i_op == pdsd_pkg::OP_LOAD_D) || (i_op == pdsd_pkg::OP_LOAD_S);
        if (i_op == pdsd_pkg::OP_LOAD_D) begin
            div_steps    = pdsd_pkg::STEP_W'(pdsd_pkg::DERIV_STEPS);
            div_dividend = {num_mag, {(DV-NW){1'b0}}};
            div_divisor  = {period, 3'b000};
        end else begin
            div_steps    = pdsd_pkg::STEP_W'(pdsd_pkg::SCALE_STEPS);
            div_dividend = acc_mag;
            div_divisor  = pdsd_pkg::SCALE;
        end

        // both quotients stay below 2^24 in magnitude
        quo_s = $signed(quo[EW-1:0]);

        // deadband away from zero, zero counts as not positive
        if (r_val > 0) begin
            comp = FW'(r_val) + $signed(FW'(i_cfg.deadband_comp));
        end else begin
            comp = FW'(r_val) - $signed(FW'(i_cfg.deadband_comp));
        end
        lo = FW'(i_cfg.out_min);
        hi = FW'(i_cfg.out_max);
        clamped = comp;
        if (clamped < lo) begin
            clamped = lo;
        end
        if (clamped > hi) begin
            clamped = hi;
        end
    end

    pdsd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_last     (o_div_last),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pdsd_pkg::HIST_D; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_op == pdsd_pkg::OP_ACCEPT) begin
            r_hist[0] <= err;
            for (int i = 1; i < pdsd_pkg::HIST_D; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            pdsd_pkg::OP_NUM:    r_num   <= num;
            pdsd_pkg::OP_FIX_D:  r_deriv <= r_num[NW-1] ? -quo_s : quo_s;
            pdsd_pkg::OP_MUL_P:  r_prod  <= prod;
            pdsd_pkg::OP_MUL_D: begin
                r_acc  <= r_prod;
                r_prod <= prod;
            end
            pdsd_pkg::OP_ADD:    r_acc   <= r_acc + r_prod;
            pdsd_pkg::OP_FIX_S:  r_val   <= r_acc[PW-1] ? -quo_s : quo_s;
            pdsd_pkg::OP_FINISH: r_drive <= clamped[pdsd_pkg::DRV_W-1:0];
            default: ;
        endcase
    end

    assign o_drive = r_drive;

endmodule

// File: rtl/core/pdsd_ctrl.sv
module pdsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  logic           i_div_last,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output pdsd_pkg::t_op  o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NUM,
        S_LOAD_D,
        S_DIV_D,
        S_FIX_D,
        S_MUL_P,
        S_MUL_D,
        S_ADD,
        S_LOAD_S,
        S_DIV_S,
        S_FIX_S,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_op    = pdsd_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = pdsd_pkg::OP_ACCEPT;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                o_op    = pdsd_pkg::OP_NUM;
                n_state = S_LOAD_D;
            end
            S_LOAD_D: begin
                o_op    = pdsd_pkg::OP_LOAD_D;
                n_state = S_DIV_D;
            end
            S_DIV_D: begin
                if (i_div_last) begin
                    n_state = S_FIX_D;
                end
            end
            S_FIX_D: begin
                o_op    = pdsd_pkg::OP_FIX_D;
                n_state = S_MUL_P;
            end
            S_MUL_P: begin
                o_op    = pdsd_pkg::OP_MUL_P;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                o_op    = pdsd_pkg::OP_MUL_D;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_op    = pdsd_pkg::OP_ADD;
                n_state = S_LOAD_S;
            end
            S_LOAD_S: begin
                o_op    = pdsd_pkg::OP_LOAD_S;
                n_state = S_DIV_S;
            end
            S_DIV_S: begin
                if (i_div_last) begin
                    n_state = S_FIX_S;
                end
            end
            S_FIX_S: begin
                o_op    = pdsd_pkg::OP_FIX_S;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_op    = pdsd_pkg::OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == pdsd_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == pdsd_pkg::OP_FINISH) |=> r_out_valid)
        else $error("result loaded without valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (o_op != pdsd_pkg::OP_FINISH))
        else $error("stalled result overwritten");

    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD_D || r_state == S_LOAD_S) |=> !i_div_last ||
        $past(r_state) == S_LOAD_D || $past(r_state) == S_LOAD_S)
        else $error("divider finished right after start");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == pdsd_pkg::OP_ACCEPT) |=> (r_state == S_NUM))
        else $error("accept did not start the sequence");

endmodule
